### hw/rtl/cppr_pkg.sv
// ----------------------------------------------------------------------------
// cppr_pkg
// Shared types and constants for the camera picture packet receiver: request
// payloads, result descriptors, frame bytes and status codes.
// ----------------------------------------------------------------------------
package cppr_pkg;

    localparam int LENGTH_BITS  = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int FRAME_LEN    = 6;
    localparam int BEAT_W       = 3;

    localparam logic [23:0] LENGTH_MASK = 24'((25'd1 << LENGTH_BITS) - 25'd1);
    localparam logic [23:0] ADDR_MAX    = 24'hFFFFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_SIZE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_CAPACITY = 2'd1;

    localparam logic [12:0] CHUNK_SIZE_RESET      = 13'd512;
    localparam logic [23:0] BUFFER_CAPACITY_RESET = 24'hFFFFFF;

    localparam logic [7:0] SYNC_BYTE    = 8'hAA;
    localparam logic [7:0] ID_ACK       = 8'h0E;
    localparam logic [7:0] ID_GETPIC    = 8'h04;
    localparam logic [7:0] ID_LEN       = 8'h0A;
    localparam logic [7:0] ACK_PARAM    = 8'h04;
    localparam logic [7:0] LEN_PARAM    = 8'h01;
    localparam logic [7:0] GETPIC_PARAM = 8'h01;
    localparam logic [15:0] FINAL_ACK_ID = 16'hF0F0;

    localparam logic OP_START = 1'b0;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_TX     = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;
    localparam logic [1:0] STATUS_SMALL = 2'd3;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_ACK     = 9'b000000010,
        PH_LEN     = 9'b000000100,
        PH_HDR     = 9'b000001000,
        PH_PAYLOAD = 9'b000010000,
        PH_CHECK   = 9'b000100000,
        PH_DONE    = 9'b001000000,
        PH_ERROR   = 9'b010000000,
        PH_SMALL   = 9'b100000000
    } phase_t;

    typedef enum logic [1:0] {
        BURST_ONE    = 2'd0,
        BURST_GETPIC = 2'd1,
        BURST_ACK    = 2'd2
    } burst_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [23:0] data_addr;
        logic [1:0]  status;
        logic [23:0] received_total;
        logic        last;
    } out_item_t;

    typedef struct packed {
        burst_t      burst;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [23:0] addr;
        logic [15:0] ack_id;
        logic [1:0]  status;
        logic [23:0] total;
    } desc_t;

    function automatic logic [7:0] frame_byte(input burst_t burst,
                                              input logic [BEAT_W-1:0] beat,
                                              input logic [15:0] ack_id);
        logic [7:0] b;
        b = 8'h00;
        case (beat)
            3'd0: b = SYNC_BYTE;
            3'd1: b = (burst == BURST_GETPIC) ? ID_GETPIC : ID_ACK;
            3'd2: b = (burst == BURST_GETPIC) ? GETPIC_PARAM : 8'h00;
            3'd3: b = 8'h00;
            3'd4: b = (burst == BURST_ACK) ? ack_id[7:0] : 8'h00;
            3'd5: b = (burst == BURST_ACK) ? ack_id[15:8] : 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/cppr_tx.sv
// ----------------------------------------------------------------------------
// cppr_tx
// Result register and beat sequencer: holds one descriptor and plays it out
// as a single result or as a six-byte command frame.
// ----------------------------------------------------------------------------
module cppr_tx (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  cppr_pkg::desc_t    desc,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output cppr_pkg::out_item_t m_data
);
    import cppr_pkg::*;

    desc_t             desc_reg;
    logic              valid_reg;
    logic              valid_next;
    logic [BEAT_W-1:0] beat_reg;
    logic [BEAT_W-1:0] beat_next;
    logic              is_last;

    assign is_last = (desc_reg.burst == BURST_ONE) ||
                     (beat_reg == BEAT_W'(FRAME_LEN - 1));
    assign free    = !valid_reg || (m_ready && is_last);
    assign m_valid = valid_reg;

    always_comb begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (load) begin
            valid_next = 1'b1;
            beat_next  = '0;
        end else if (valid_reg && m_ready) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                beat_next = beat_reg + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            desc_reg <= desc;
        end
    end

    always_comb begin
        m_data.status         = desc_reg.status;
        m_data.received_total = desc_reg.total;
        m_data.last           = is_last;
        if (desc_reg.burst == BURST_ONE) begin
            m_data.out_kind  = desc_reg.kind;
            m_data.out_byte  = desc_reg.data_byte;
            m_data.data_addr = desc_reg.addr;
        end else begin
            m_data.out_kind  = KIND_TX;
            m_data.out_byte  = frame_byte(desc_reg.burst, beat_reg, desc_reg.ack_id);
            m_data.data_addr = '0;
        end
    end

    a_single_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && desc_reg.burst == BURST_ONE |-> beat_reg == '0)
        else $error("single result past its first beat");

    a_beat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> beat_reg < BEAT_W'(FRAME_LEN))
        else $error("beat counter beyond frame length");

    a_frame_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && m_ready && !is_last |=> valid_reg && beat_reg == $past(beat_reg) + 3'd1)
        else $error("frame beat skipped or dropped");

    a_nontx_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind != KIND_TX |-> m_data.last)
        else $error("status or data result not marked last");

endmodule

### hw/rtl/camera_picture_packet_receiver.sv
// ----------------------------------------------------------------------------
// camera_picture_packet_receiver
// Host side of a serial camera picture transfer: sends GET PICTURE, parses
// ACK, length and data packets, acknowledges length and data packets, gives out data.
// ----------------------------------------------------------------------------
// result: the first result is valid in the cycle after the request is accepted
// throughput: one request per cycle when each gives one result and m_ready is
//   high; a request that sends a frame holds the result port until its six bytes are taken
// reset: synchronous active-low aresetn; phase idle, counters cleared,
//   chunk_size 512, buffer_capacity 16777215
module camera_picture_packet_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cppr_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cppr_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cppr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cppr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cppr_pkg::*;

    logic [12:0] chunk_size_reg;
    logic [23:0] capacity_reg;

    phase_t      phase_reg,  phase_next;
    logic [15:0] fbc_reg,    fbc_next;
    logic [23:0] len_reg,    len_next;
    logic [23:0] rc_reg,     rc_next;
    logic [15:0] id_reg,     id_next;
    logic [15:0] psize_reg,  psize_next;
    logic [23:0] base_reg,   base_next;

    logic        accept;
    logic        tx_free;
    desc_t       desc;

    logic [15:0] pos_inc;
    logic [23:0] len_upd;
    logic [15:0] psize_upd;
    logic [7:0]  exp1;
    logic [7:0]  exp2;
    logic        bad;
    logic [23:0] pay_addr;
    logic [15:0] id_inc;
    logic [23:0] step;
    logic [23:0] prod;

    assign cfg_ready = 1'b1;
    assign s_ready   = tx_free;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= CHUNK_SIZE_RESET;
            capacity_reg   <= BUFFER_CAPACITY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CHUNK_SIZE:      chunk_size_reg <= cfg_data[12:0];
                REG_BUFFER_CAPACITY: capacity_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign pos_inc  = fbc_reg + 16'd1;
    assign pay_addr = base_reg + {8'd0, fbc_reg};
    assign id_inc   = id_reg + 16'd1;
    assign step     = 24'(chunk_size_reg) - 24'd6;
    assign prod     = step * {8'd0, id_inc};
    assign exp1     = (phase_reg == PH_ACK) ? ID_ACK : ID_LEN;
    assign exp2     = (phase_reg == PH_ACK) ? ACK_PARAM : LEN_PARAM;

    always_comb begin
        len_upd = len_reg;
        if (phase_reg == PH_LEN) begin
            case (fbc_reg)
                16'd3: len_upd = len_reg | {16'd0, s_data.rx_byte};
                16'd4: len_upd = len_reg | {8'd0, s_data.rx_byte, 8'd0};
                16'd5: len_upd = len_reg | {s_data.rx_byte, 16'd0};
                default: len_upd = len_reg;
            endcase
        end
        len_upd = len_upd & LENGTH_MASK;
    end

    always_comb begin
        psize_upd = psize_reg;
        case (fbc_reg)
            16'd2: psize_upd = {psize_reg[15:8], s_data.rx_byte};
            16'd3: psize_upd = {s_data.rx_byte, psize_reg[7:0]};
            default: psize_upd = psize_reg;
        endcase
    end

    always_comb begin
        bad = 1'b0;
        case (fbc_reg)
            16'd0: bad = (s_data.rx_byte != SYNC_BYTE);
            16'd1: bad = (s_data.rx_byte != exp1);
            16'd2: bad = (s_data.rx_byte != exp2);
            default: bad = 1'b0;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        len_next   = len_reg;
        rc_next    = rc_reg;
        id_next    = id_reg;
        psize_next = psize_reg;
        base_next  = base_reg;

        desc.burst     = BURST_ONE;
        desc.kind      = KIND_STATUS;
        desc.data_byte = 8'h00;
        desc.addr      = '0;
        desc.ack_id    = '0;

        if (s_data.operation == OP_START) begin
            phase_next = PH_ACK;
            fbc_next   = '0;
            len_next   = '0;
            rc_next    = '0;
            id_next    = '0;
            psize_next = '0;
            base_next  = '0;
            desc.burst = BURST_GETPIC;
        end else begin
            case (phase_reg)
                PH_ACK, PH_LEN: begin
                    fbc_next = pos_inc;
                    len_next = len_upd;
                    if (bad) begin
                        phase_next = PH_ERROR;
                    end else if (fbc_reg >= 16'd5) begin
                        fbc_next = '0;
                        if (phase_reg == PH_ACK) begin
                            phase_next = PH_LEN;
                            len_next   = '0;
                        end else if (len_upd >= capacity_reg) begin
                            phase_next = PH_SMALL;
                        end else begin
                            phase_next = PH_HDR;
                            id_next    = '0;
                            base_next  = '0;
                            desc.burst = BURST_ACK;
                        end
                    end
                end
                PH_HDR: begin
                    psize_next = psize_upd;
                    fbc_next   = pos_inc;
                    if (fbc_reg >= 16'd3) begin
                        fbc_next   = '0;
                        phase_next = (psize_upd == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (pay_addr < capacity_reg) begin
                        desc.kind      = KIND_DATA;
                        desc.data_byte = s_data.rx_byte;
                        desc.addr      = pay_addr;
                    end
                    if (rc_reg < ADDR_MAX) begin
                        rc_next = rc_reg + 24'd1;
                    end
                    fbc_next = pos_inc;
                    if (pos_inc >= psize_reg) begin
                        fbc_next   = '0;
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    fbc_next = pos_inc;
                    if (fbc_reg >= 16'd1) begin
                        fbc_next   = '0;
                        desc.burst = BURST_ACK;
                        if (rc_reg >= len_reg) begin
                            phase_next  = PH_DONE;
                            desc.ack_id = FINAL_ACK_ID;
                        end else begin
                            id_next     = id_inc;
                            base_next   = prod;
                            phase_next  = PH_HDR;
                            desc.ack_id = id_inc;
                        end
                    end
                end
                default: ;
            endcase
        end

        case (phase_next)
            PH_DONE:  desc.status = STATUS_DONE;
            PH_ERROR: desc.status = STATUS_ERROR;
            PH_SMALL: desc.status = STATUS_SMALL;
            default:  desc.status = STATUS_BUSY;
        endcase
        desc.total = rc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            fbc_reg   <= '0;
            len_reg   <= '0;
            rc_reg    <= '0;
            id_reg    <= '0;
            psize_reg <= '0;
            base_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            len_reg   <= len_next;
            rc_reg    <= rc_next;
            id_reg    <= id_next;
            psize_reg <= psize_next;
            base_reg  <= base_next;
        end
    end

    cppr_tx u_tx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .desc    (desc),
        .free    (tx_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_start_sends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.operation == OP_START |=> m_valid && m_data.out_kind == KIND_TX
            && phase_reg == PH_ACK && rc_reg == '0)
        else $error("start request did not begin transfer");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.operation != OP_START |=> rc_reg >= $past(rc_reg))
        else $error("received count went backwards");

endmodule
